// ===== hw/rtl/xs16_pkg.sv =====
package xs16_pkg;

	// Item kind carried on the input tuser.
	typedef enum logic {
		CMD_SEED = 1'b0,
		CMD_DRAW = 1'b1
	} cmd_t;

	localparam int unsigned STATE_W   = 16;
	localparam int unsigned SPAN_W    = STATE_W + 1;
	localparam int unsigned NUM_CELLS = STATE_W;

	localparam logic [STATE_W-1:0] ESCAPE_IN    = 16'h560A;
	localparam logic [STATE_W-1:0] SHIFT_MASK   = 16'hFF80;
	localparam logic [STATE_W-1:0] ESCAPE_ZERO  = 16'hAA55;
	localparam logic [STATE_W-1:0] EVEN_MASK    = 16'h1FF4;
	localparam logic [STATE_W-1:0] ODD_MASK     = 16'h8180;

	// Payload that moves down the remainder chain.
	typedef struct packed {
		logic [STATE_W-1:0] raw;
		logic [STATE_W-1:0] dvd;
		logic [STATE_W-1:0] rem;
		logic [SPAN_W-1:0]  span;
		logic [STATE_W-1:0] low;
		logic               is_draw;
		logic               err;
	} item_t;

	// One step of the generator.
	function automatic logic [STATE_W-1:0] advance(input logic [STATE_W-1:0] x);
		logic [STATE_W-1:0] v;
		logic [STATE_W-1:0] s0;
		logic [STATE_W-1:0] s1;
		logic [STATE_W-1:0] res;
		v  = (x == ESCAPE_IN) ? '0 : x;
		s0 = {v[7:0], 8'h00} ^ v;
		s1 = (s0 >> 1) ^ SHIFT_MASK;
		if (s0[0] == 1'b0) begin
			res = (s1 == ESCAPE_ZERO) ? '0 : (s1 ^ EVEN_MASK);
		end else begin
			res = s1 ^ ODD_MASK;
		end
		return res;
	endfunction

endpackage

// ===== hw/rtl/xs16_cell.sv =====
// One restoring remainder step: brings in the next dividend bit and
// subtracts the span when it fits.
module xs16_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  xs16_pkg::item_t in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output xs16_pkg::item_t out_item
);

	logic            valid_q;
	xs16_pkg::item_t item_q;
	xs16_pkg::item_t nxt_item;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_comb begin
		logic [xs16_pkg::SPAN_W-1:0] shifted;
		logic [xs16_pkg::SPAN_W-1:0] diff;
		nxt_item = in_item;
		shifted  = {in_item.rem, in_item.dvd[xs16_pkg::STATE_W-1]};
		diff     = shifted - in_item.span;
		nxt_item.dvd = {in_item.dvd[xs16_pkg::STATE_W-2:0], 1'b0};
		if (shifted >= in_item.span) begin
			nxt_item.rem = diff[xs16_pkg::STATE_W-1:0];
		end else begin
			nxt_item.rem = shifted[xs16_pkg::STATE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= nxt_item;
		end
	end

`ifndef SYNTHESIS
	// On a draw without a range error, the partial remainder stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && item_q.is_draw && !item_q.err
			|-> {1'b0, item_q.rem} < item_q.span)
		else $error("partial remainder not below span");
`endif

endmodule

// ===== hw/rtl/xs16_gen.sv =====
// Generator state and front stage: loads or advances the state and sets up
// the remainder work for the chain.
module xs16_gen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  xs16_pkg::cmd_t                 cmd,
	input  logic [xs16_pkg::STATE_W-1:0]   seed_value,
	input  logic [xs16_pkg::STATE_W-1:0]   range_low,
	input  logic [xs16_pkg::STATE_W-1:0]   range_high,
	output logic                           out_valid,
	input  logic                           out_ready,
	output xs16_pkg::item_t                out_item
);

	logic                         valid_q;
	logic [xs16_pkg::STATE_W-1:0] state_q;
	logic [xs16_pkg::STATE_W-1:0] nxt_state;
	xs16_pkg::item_t              item_q;
	xs16_pkg::item_t              nxt_item;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_comb begin
		nxt_item.rem  = '0;
		nxt_item.low  = range_low;
		nxt_item.span = {1'b0, range_high} - {1'b0, range_low} + 1'b1;
		unique case (cmd)
			xs16_pkg::CMD_SEED: begin
				nxt_state        = seed_value;
				nxt_item.is_draw = 1'b0;
				nxt_item.err     = 1'b0;
			end
			xs16_pkg::CMD_DRAW: begin
				nxt_state        = xs16_pkg::advance(state_q);
				nxt_item.is_draw = 1'b1;
				nxt_item.err     = (range_high < range_low);
			end
			default: begin
				nxt_state        = state_q;
				nxt_item.is_draw = 1'b0;
				nxt_item.err     = 1'b0;
			end
		endcase
		nxt_item.raw = nxt_state;
		nxt_item.dvd = nxt_state;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			state_q <= '0;
		end else if (in_ready) begin
			valid_q <= in_valid;
			if (in_valid) begin
				state_q <= nxt_state;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_q <= nxt_item;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == xs16_pkg::CMD_SEED
			|=> state_q == $past(seed_value))
		else $error("seed not loaded into state");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && cmd == xs16_pkg::CMD_DRAW
			|=> state_q == xs16_pkg::advance($past(state_q)))
		else $error("draw did not advance state by one step");
`endif

endmodule

// ===== hw/rtl/xor_shift16_random_range.sv =====
// Sixteen-bit xor-shift random generator with a ranged draw. A transaction
// with tuser low loads seed_value into the generator state and echoes it as
// the raw value; one with tuser high advances the state by one xor-shift step
// and returns the new state, its low bit as a coin flip, and
// range_low + (raw mod (range_high - range_low + 1)) wrapped to 16 bits.
// When range_high is below range_low the draw still advances the state, the
// range_error flag is set and the ranged value is range_low. Every input
// transaction yields exactly one output transaction, in order. The block
// accepts one transaction per cycle while the output is not stalled. A
// result passes through the state update register, a chain of 16
// remainder cells that each resolve one dividend bit, and the output
// register. The sustained rate is set by the state update, a combinational
// xor network, since the cell chain passes work forward every cycle. Backpressure
// on the output fills bubbles in the chain before it reaches the input.
module xor_shift16_random_range (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] seed_value, [31:16] range_low, [47:32] range_high
	input  logic [47:0] s_axis_tdata,
	// [0] cmd
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] raw_value, [16] coin_bit, [32:17] ranged_value, [39:33] zero
	output logic [39:0] m_axis_tdata,
	// [0] range_error
	output logic        m_axis_tuser
);

	// Handshake and payload between the front stage, the cells and the
	// output register; index 0 is the front stage output.
	logic            chain_valid [0:xs16_pkg::NUM_CELLS];
	logic            chain_ready [0:xs16_pkg::NUM_CELLS];
	xs16_pkg::item_t chain_item  [0:xs16_pkg::NUM_CELLS];

	logic                         out_valid_q;
	logic [xs16_pkg::STATE_W-1:0] raw_q;
	logic [xs16_pkg::STATE_W-1:0] ranged_q;
	logic                         err_q;
	logic [xs16_pkg::STATE_W-1:0] ranged_d;
	logic                         out_load;
	xs16_pkg::item_t              last_item;

	xs16_gen u_gen (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.cmd        (xs16_pkg::cmd_t'(s_axis_tuser)),
		.seed_value (s_axis_tdata[15:0]),
		.range_low  (s_axis_tdata[31:16]),
		.range_high (s_axis_tdata[47:32]),
		.out_valid  (chain_valid[0]),
		.out_ready  (chain_ready[0]),
		.out_item   (chain_item[0])
	);

	// Each cell takes the next most significant bit of the raw value into
	// its partial remainder, so after the last cell the remainder is final.
	for (genvar i = 0; i < xs16_pkg::NUM_CELLS; i++) begin : g_cells
		xs16_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_ready  (chain_ready[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_ready (chain_ready[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	assign last_item = chain_item[xs16_pkg::NUM_CELLS];

	// The output register frees itself when the downstream side takes the
	// result, so a waiting result does not block the cell in front of it
	// longer than needed.
	assign chain_ready[xs16_pkg::NUM_CELLS] = !out_valid_q || m_axis_tready;
	assign out_load = chain_ready[xs16_pkg::NUM_CELLS]
		&& chain_valid[xs16_pkg::NUM_CELLS];

	// A seed reports zero, an inverted range reports the low bound, and a
	// normal draw adds the remainder to the low bound with a 16-bit wrap.
	always_comb begin
		priority if (!last_item.is_draw) begin
			ranged_d = '0;
		end else if (last_item.err) begin
			ranged_d = last_item.low;
		end else begin
			ranged_d = last_item.low + last_item.rem;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (chain_ready[xs16_pkg::NUM_CELLS]) begin
			out_valid_q <= chain_valid[xs16_pkg::NUM_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			raw_q    <= last_item.raw;
			ranged_q <= ranged_d;
			err_q    <= last_item.err;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, ranged_q, raw_q[0], raw_q};
	assign m_axis_tuser  = err_q;

`ifndef SYNTHESIS
	// A result leaving the chain as a seed never carries an error flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load && !last_item.is_draw |=> !m_axis_tuser)
		else $error("seed result flagged as range error");
`endif

endmodule
